// ===== hdl/nnta_pkg.sv =====
// nnta_pkg: shared types, constants and helpers of the track associator
// depends on nothing; imported by nnta_ctrl, nnta_datapath and the top level
`default_nettype none

package nnta_pkg;

	localparam int DEF_MAX_TRACKS   = 32;
	localparam int DEF_MAX_CLUSTERS = 32;
	localparam int RESULT_CAP       = 32;
	localparam int N_W              = $clog2(RESULT_CAP + 1);

	localparam int POS_W     = 24;
	localparam int RAD_W     = 16;
	localparam int ID_W      = 32;
	localparam int MISS_W    = 8;
	localparam int DT_W      = 24;
	localparam int CFG_W     = 23;
	localparam int CFG_IDX_W = 2;

	localparam int DIFF_W = POS_W + 1;
	localparam int ACC_W  = 2 * DIFF_W;
	localparam int GAIN_W = 28;
	localparam int PROD_W = DIFF_W + GAIN_W - 1;
	localparam int MAG_W  = PROD_W - 1;
	localparam int MIX_W  = PROD_W + 1;

	localparam logic [CFG_IDX_W-1:0] CFG_GATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DYN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MISS = 2'd2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_CLOSE = 1'b1;

	localparam logic [CFG_W-1:0]  GATE_RST = 23'd2048;
	localparam logic [CFG_W-1:0]  DYN_RST  = 23'd512;
	localparam logic [MISS_W-1:0] MISS_RST = 8'd5;
	localparam logic [MISS_W-1:0] MISS_SAT = 8'hff;

	localparam int VEL_GAIN  = 77000000;
	localparam int OLD_GAIN  = 179;
	localparam int MIX_SHIFT = 8;

	// track write sources
	localparam logic [1:0] TW_UPDATE = 2'd0;
	localparam logic [1:0] TW_MISS   = 2'd1;
	localparam logic [1:0] TW_MOVE   = 2'd2;
	localparam logic [1:0] TW_NEW    = 2'd3;

	// accumulator ops
	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_CLR  = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	// output ops
	localparam logic [2:0] EM_NONE  = 3'd0;
	localparam logic [2:0] EM_LOAD  = 3'd1;
	localparam logic [2:0] EM_SHIFT = 3'd2;
	localparam logic [2:0] EM_LAST  = 3'd3;
	localparam logic [2:0] EM_EMPTY = 3'd4;

	typedef struct packed {
		logic                    command;
		logic signed [POS_W-1:0] cluster_x;
		logic signed [POS_W-1:0] cluster_y;
		logic signed [POS_W-1:0] cluster_z;
		logic [RAD_W-1:0]        cluster_radius;
		logic [DT_W-1:0]         frame_dt;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]         track_id;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [RAD_W-1:0]        radius;
		logic signed [POS_W-1:0] vel_x;
		logic signed [POS_W-1:0] vel_y;
		logic signed [POS_W-1:0] vel_z;
		logic                    is_dynamic;
		logic                    last_of_frame;
		logic                    no_live_tracks;
		logic                    dropped_any;
	} out_item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] pz;
		logic signed [POS_W-1:0] vx;
		logic signed [POS_W-1:0] vy;
		logic signed [POS_W-1:0] vz;
		logic [RAD_W-1:0]        rad;
		logic [ID_W-1:0]         ident;
		logic [MISS_W-1:0]       missed;
		logic                    moving;
	} track_rec_t;

	typedef struct packed {
		logic signed [POS_W-1:0] cx;
		logic signed [POS_W-1:0] cy;
		logic signed [POS_W-1:0] cz;
		logic [RAD_W-1:0]        crad;
	} clu_rec_t;

	typedef struct packed {
		logic       close_lat;
		logic       clu_we;
		logic       trk_we;
		logic [1:0] trk_wsel;
		logic [1:0] ax;
		logic       sq_dyn;
		logic [1:0] acc_op;
		logic       bd_init;
		logic       bd_take;
		logic       vel_init;
		logic       prod_load;
		logic       div_start;
		logic       vel_mix;
		logic [2:0] emit_op;
		logic       dropped;
	} ctrl_cmd_t;

	typedef struct packed {
		logic d2_less;
		logic div_done;
		logic stale;
		logic fresh;
		logic dt_gt1;
	} dp_status_t;

	function automatic logic signed [POS_W-1:0] pick_axis(
		input logic [1:0]              ax,
		input logic signed [POS_W-1:0] x,
		input logic signed [POS_W-1:0] y,
		input logic signed [POS_W-1:0] z
	);
		logic signed [POS_W-1:0] r;
		unique case (ax)
			2'd0: r = x;
			2'd1: r = y;
			default: r = z;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/nnta_ram.sv =====
// nnta_ram: generic single write port, single read port ram, registered read
// depends on nothing
`default_nettype none

module nnta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/nnta_div.sv =====
// nnta_div: unsigned restoring divider, one quotient bit per cycle
// depends on nothing
`default_nettype none

module nnta_div #(
	parameter int NUM_W = 51,
	parameter int DEN_W = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   trial_sub;
	logic             fits;

	always_comb begin
		trial     = {rem_q, quo_q[NUM_W-1]};
		trial_sub = trial - {1'b0, den_q};
		fits      = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// ===== hdl/nnta_ctrl.sv =====
// nnta_ctrl: frame sequencer, loop counters, claim bits and table fill counts
// depends on nnta_pkg
`default_nettype none

module nnta_ctrl import nnta_pkg::*; #(
	parameter int MAX_TRACKS   = DEF_MAX_TRACKS,
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
	parameter int TAW          = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1,
	parameter int CAW          = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           command,
	output logic                busy,
	input  wire dp_status_t     stat,
	output ctrl_cmd_t           cmd,
	output logic      [TAW-1:0] trk_raddr,
	output logic      [TAW-1:0] trk_waddr,
	output logic      [CAW-1:0] clu_raddr,
	output logic      [CAW-1:0] clu_waddr
);

	localparam int CWT = $clog2(MAX_TRACKS + 1);
	localparam int CWC = $clog2(MAX_CLUSTERS + 1);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_A_TRK = 5'd1;
	localparam logic [4:0] S_A_CHK = 5'd2;
	localparam logic [4:0] S_A_AX  = 5'd3;
	localparam logic [4:0] S_A_CMP = 5'd4;
	localparam logic [4:0] S_A_DEC = 5'd5;
	localparam logic [4:0] S_V_RD  = 5'd6;
	localparam logic [4:0] S_V_MUL = 5'd7;
	localparam logic [4:0] S_V_DST = 5'd8;
	localparam logic [4:0] S_V_DWT = 5'd9;
	localparam logic [4:0] S_V_MIX = 5'd10;
	localparam logic [4:0] S_V_DYN = 5'd11;
	localparam logic [4:0] S_V_WR  = 5'd12;
	localparam logic [4:0] S_C_RD  = 5'd13;
	localparam logic [4:0] S_C_EV  = 5'd14;
	localparam logic [4:0] S_N_CHK = 5'd15;
	localparam logic [4:0] S_N_WR  = 5'd16;
	localparam logic [4:0] S_E_RD  = 5'd17;
	localparam logic [4:0] S_E_EV  = 5'd18;
	localparam logic [4:0] S_E_END = 5'd19;

	logic [4:0]              state_q;
	logic [CWT-1:0]          t_q;
	logic [CWT-1:0]          w_q;
	logic [CWT-1:0]          tcount_q;
	logic [CWC-1:0]          c_q;
	logic [CWC-1:0]          ccount_q;
	logic [CAW-1:0]          best_q;
	logic                    best_v_q;
	logic [1:0]              ax_q;
	logic [N_W-1:0]          n_q;
	logic                    pend_v_q;
	logic [MAX_CLUSTERS-1:0] taken_q;
	logic                    ovf_q;
	logic                    v_state;

	assign busy      = (state_q != S_IDLE);
	assign trk_raddr = t_q[TAW-1:0];
	assign clu_waddr = ccount_q[CAW-1:0];
	assign v_state   = (state_q == S_V_RD) || (state_q == S_V_MUL) || (state_q == S_V_DST) ||
		(state_q == S_V_DWT) || (state_q == S_V_MIX) || (state_q == S_V_DYN) ||
		(state_q == S_V_WR);
	assign clu_raddr = v_state ? best_q : c_q[CAW-1:0];

	always_comb begin
		unique case (state_q)
			S_C_EV:  trk_waddr = w_q[TAW-1:0];
			S_N_WR:  trk_waddr = tcount_q[TAW-1:0];
			default: trk_waddr = t_q[TAW-1:0];
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.ax      = ax_q;
		cmd.dropped = ovf_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.close_lat = start && (command == CMD_CLOSE);
				cmd.clu_we    = start && (command == CMD_LOAD) &&
					(ccount_q != CWC'(MAX_CLUSTERS));
			end
			S_A_TRK: cmd.bd_init = 1'b1;
			S_A_AX:  cmd.acc_op = (ax_q == 2'd0) ? ACC_CLR : ACC_ADD;
			S_A_CMP: cmd.bd_take = stat.d2_less;
			S_A_DEC: begin
				cmd.vel_init = best_v_q;
				cmd.trk_we   = !best_v_q;
				cmd.trk_wsel = TW_MISS;
			end
			S_V_MUL: cmd.prod_load = 1'b1;
			S_V_DST: cmd.div_start = 1'b1;
			S_V_MIX: cmd.vel_mix = 1'b1;
			S_V_DYN: begin
				cmd.sq_dyn = 1'b1;
				cmd.acc_op = (ax_q == 2'd0) ? ACC_CLR : ACC_ADD;
			end
			S_V_WR: begin
				cmd.trk_we   = 1'b1;
				cmd.trk_wsel = TW_UPDATE;
			end
			S_C_EV: begin
				cmd.trk_we   = !stat.stale;
				cmd.trk_wsel = TW_MOVE;
			end
			S_N_WR: begin
				cmd.trk_we   = 1'b1;
				cmd.trk_wsel = TW_NEW;
			end
			S_E_EV: begin
				if (stat.fresh) begin
					cmd.emit_op = pend_v_q ? EM_SHIFT : EM_LOAD;
				end
			end
			S_E_END: cmd.emit_op = pend_v_q ? EM_LAST : EM_EMPTY;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			t_q      <= '0;
			w_q      <= '0;
			tcount_q <= '0;
			c_q      <= '0;
			ccount_q <= '0;
			best_q   <= '0;
			best_v_q <= 1'b0;
			ax_q     <= '0;
			n_q      <= '0;
			pend_v_q <= 1'b0;
			taken_q  <= '0;
			ovf_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (command == CMD_CLOSE) begin
							t_q     <= '0;
							state_q <= S_A_TRK;
						end else if (ccount_q != CWC'(MAX_CLUSTERS)) begin
							ccount_q <= ccount_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				S_A_TRK: begin
					c_q      <= '0;
					best_v_q <= 1'b0;
					if (t_q == tcount_q) begin
						t_q     <= '0;
						w_q     <= '0;
						state_q <= S_C_RD;
					end else begin
						state_q <= S_A_CHK;
					end
				end
				S_A_CHK: begin
					priority if (c_q == ccount_q) begin
						state_q <= S_A_DEC;
					end else if (taken_q[c_q[CAW-1:0]]) begin
						c_q <= c_q + 1'b1;
					end else begin
						ax_q    <= '0;
						state_q <= S_A_AX;
					end
				end
				S_A_AX: begin
					ax_q <= ax_q + 1'b1;
					if (ax_q == 2'd3) begin
						state_q <= S_A_CMP;
					end
				end
				S_A_CMP: begin
					if (stat.d2_less) begin
						best_q   <= c_q[CAW-1:0];
						best_v_q <= 1'b1;
					end
					c_q     <= c_q + 1'b1;
					state_q <= S_A_CHK;
				end
				S_A_DEC: begin
					if (best_v_q) begin
						taken_q[best_q] <= 1'b1;
						state_q         <= S_V_RD;
					end else begin
						t_q     <= t_q + 1'b1;
						state_q <= S_A_TRK;
					end
				end
				S_V_RD: begin
					ax_q    <= '0;
					state_q <= stat.dt_gt1 ? S_V_MUL : S_V_DYN;
				end
				S_V_MUL: state_q <= S_V_DST;
				S_V_DST: state_q <= S_V_DWT;
				S_V_DWT: begin
					if (stat.div_done) begin
						state_q <= S_V_MIX;
					end
				end
				S_V_MIX: begin
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						state_q <= S_V_DYN;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= S_V_MUL;
					end
				end
				S_V_DYN: begin
					ax_q <= ax_q + 1'b1;
					if (ax_q == 2'd3) begin
						state_q <= S_V_WR;
					end
				end
				S_V_WR: begin
					t_q     <= t_q + 1'b1;
					state_q <= S_A_TRK;
				end
				S_C_RD: begin
					if (t_q == tcount_q) begin
						tcount_q <= w_q;
						c_q      <= '0;
						state_q  <= S_N_CHK;
					end else begin
						state_q <= S_C_EV;
					end
				end
				S_C_EV: begin
					if (!stat.stale) begin
						w_q <= w_q + 1'b1;
					end
					t_q     <= t_q + 1'b1;
					state_q <= S_C_RD;
				end
				S_N_CHK: begin
					priority if (c_q == ccount_q) begin
						t_q      <= '0;
						n_q      <= '0;
						pend_v_q <= 1'b0;
						state_q  <= S_E_RD;
					end else if (taken_q[c_q[CAW-1:0]]) begin
						c_q <= c_q + 1'b1;
					end else if (tcount_q == CWT'(MAX_TRACKS)) begin
						ovf_q <= 1'b1;
						c_q   <= c_q + 1'b1;
					end else begin
						state_q <= S_N_WR;
					end
				end
				S_N_WR: begin
					tcount_q <= tcount_q + 1'b1;
					c_q      <= c_q + 1'b1;
					state_q  <= S_N_CHK;
				end
				S_E_RD: begin
					if ((t_q == tcount_q) || (n_q == N_W'(RESULT_CAP))) begin
						state_q <= S_E_END;
					end else begin
						state_q <= S_E_EV;
					end
				end
				S_E_EV: begin
					if (stat.fresh) begin
						pend_v_q <= 1'b1;
						n_q      <= n_q + 1'b1;
					end
					t_q     <= t_q + 1'b1;
					state_q <= S_E_RD;
				end
				S_E_END: begin
					taken_q  <= '0;
					ccount_q <= '0;
					ovf_q    <= 1'b0;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/nnta_datapath.sv =====
// nnta_datapath: track and cluster stores, distance and velocity arithmetic,
// config registers and result registers; depends on nnta_pkg, nnta_ram, nnta_div
`default_nettype none

module nnta_datapath import nnta_pkg::*; #(
	parameter int MAX_TRACKS   = DEF_MAX_TRACKS,
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
	parameter int TAW          = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1,
	parameter int CAW          = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire in_item_t             item,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire ctrl_cmd_t            cmd,
	input  wire logic [TAW-1:0]       trk_raddr,
	input  wire logic [TAW-1:0]       trk_waddr,
	input  wire logic [CAW-1:0]       clu_raddr,
	input  wire logic [CAW-1:0]       clu_waddr,
	output dp_status_t                stat,
	output logic                      result_strobe,
	output out_item_t                 result
);

	localparam logic signed [PROD_W-1:0] GAIN_P = PROD_W'(VEL_GAIN);
	localparam logic signed [MIX_W-1:0]  OLD_M  = MIX_W'(OLD_GAIN);

	logic [CFG_W-1:0]  gate_q;
	logic [CFG_W-1:0]  dyn_q;
	logic [MISS_W-1:0] miss_q;
	logic [ACC_W-1:0]  gate2_q;
	logic [ACC_W-1:0]  dyn2_q;
	logic [DT_W-1:0]   dt_q;
	logic [ID_W-1:0]   id_q;

	track_rec_t trk_rd;
	track_rec_t trk_wd;
	clu_rec_t   clu_rd;
	clu_rec_t   clu_wd;

	logic signed [POS_W-1:0]  vnx_q;
	logic signed [POS_W-1:0]  vny_q;
	logic signed [POS_W-1:0]  vnz_q;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] sq_src;
	logic signed [ACC_W-1:0]  sq_in;
	logic signed [ACC_W-1:0]  sq_full;
	logic [ACC_W-1:0]         sq_s1;
	logic [ACC_W-1:0]         acc_q;
	logic [ACC_W-1:0]         bd_q;
	logic signed [PROD_W-1:0] p_a;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] prod_neg;
	logic [MAG_W-1:0]         prod_mag;
	logic [MAG_W-1:0]         quo;
	logic signed [PROD_W-1:0] q_s;
	logic signed [POS_W-1:0]  v_old;
	logic signed [MIX_W-1:0]  mixed;
	logic signed [MIX_W-1:0]  shifted;
	logic signed [POS_W-1:0]  v_sat;
	logic                     div_done;
	logic                     moving;
	out_item_t                pend_q;
	out_item_t                out_q;
	out_item_t                out_d;
	logic                     strobe_q;
	out_item_t                fresh_item;

	nnta_ram #(
		.WIDTH($bits(track_rec_t)),
		.DEPTH(MAX_TRACKS)
	) u_trk_ram (
		.clk  (clk),
		.we   (cmd.trk_we),
		.waddr(trk_waddr),
		.wdata(trk_wd),
		.raddr(trk_raddr),
		.rdata(trk_rd)
	);

	assign clu_wd = '{cx: item.cluster_x, cy: item.cluster_y, cz: item.cluster_z,
		crad: item.cluster_radius};

	nnta_ram #(
		.WIDTH($bits(clu_rec_t)),
		.DEPTH(MAX_CLUSTERS)
	) u_clu_ram (
		.clk  (clk),
		.we   (cmd.clu_we),
		.waddr(clu_waddr),
		.wdata(clu_wd),
		.raddr(clu_raddr),
		.rdata(clu_rd)
	);

	// distance and squared speed
	always_comb begin
		logic signed [POS_W-1:0] c_ax;
		logic signed [POS_W-1:0] t_ax;
		logic signed [POS_W-1:0] vn_ax;
		c_ax    = pick_axis(cmd.ax, clu_rd.cx, clu_rd.cy, clu_rd.cz);
		t_ax    = pick_axis(cmd.ax, trk_rd.px, trk_rd.py, trk_rd.pz);
		vn_ax   = pick_axis(cmd.ax, vnx_q, vny_q, vnz_q);
		diff    = {c_ax[POS_W-1], c_ax} - {t_ax[POS_W-1], t_ax};
		sq_src  = cmd.sq_dyn ? {vn_ax[POS_W-1], vn_ax} : diff;
		sq_in   = {{(ACC_W-DIFF_W){sq_src[DIFF_W-1]}}, sq_src};
		sq_full = sq_in * sq_in;
		p_a     = {{(PROD_W-DIFF_W){diff[DIFF_W-1]}}, diff};
		prod    = p_a * GAIN_P;
	end

	// velocity blend
	always_comb begin
		logic signed [MIX_W-1:0] v_ext;
		logic signed [MIX_W-1:0] q_ext;
		logic [MIX_W-POS_W:0]    hi;
		prod_neg = -prod_s1;
		prod_mag = prod_s1[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod_s1[MAG_W-1:0];
		q_s      = prod_s1[PROD_W-1] ? -{1'b0, quo} : {1'b0, quo};
		v_old    = pick_axis(cmd.ax, trk_rd.vx, trk_rd.vy, trk_rd.vz);
		v_ext    = {{(MIX_W-POS_W){v_old[POS_W-1]}}, v_old};
		q_ext    = {q_s[PROD_W-1], q_s};
		mixed    = v_ext * OLD_M + q_ext;
		shifted  = mixed >>> MIX_SHIFT;
		hi       = shifted[MIX_W-1:POS_W-1];
		if ((&hi) || (~|hi)) begin
			v_sat = shifted[POS_W-1:0];
		end else if (shifted[MIX_W-1]) begin
			v_sat = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			v_sat = {1'b0, {(POS_W-1){1'b1}}};
		end
	end

	nnta_div #(
		.NUM_W(MAG_W),
		.DEN_W(DT_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (prod_mag),
		.den   (dt_q),
		.done  (div_done),
		.quo   (quo)
	);

	assign moving = (acc_q > dyn2_q);

	always_comb begin
		trk_wd = trk_rd;
		unique case (cmd.trk_wsel)
			TW_UPDATE: begin
				trk_wd.px     = clu_rd.cx;
				trk_wd.py     = clu_rd.cy;
				trk_wd.pz     = clu_rd.cz;
				trk_wd.rad    = clu_rd.crad;
				trk_wd.vx     = vnx_q;
				trk_wd.vy     = vny_q;
				trk_wd.vz     = vnz_q;
				trk_wd.missed = '0;
				trk_wd.moving = moving;
			end
			TW_MISS: begin
				if (trk_rd.missed != MISS_SAT) begin
					trk_wd.missed = trk_rd.missed + 1'b1;
				end
			end
			TW_MOVE: begin
			end
			TW_NEW: begin
				trk_wd.px     = clu_rd.cx;
				trk_wd.py     = clu_rd.cy;
				trk_wd.pz     = clu_rd.cz;
				trk_wd.rad    = clu_rd.crad;
				trk_wd.vx     = '0;
				trk_wd.vy     = '0;
				trk_wd.vz     = '0;
				trk_wd.ident  = id_q;
				trk_wd.missed = '0;
				trk_wd.moving = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign stat.d2_less  = (acc_q < bd_q);
	assign stat.div_done = div_done;
	assign stat.stale    = (trk_rd.missed > miss_q);
	assign stat.fresh    = (trk_rd.missed == '0);
	assign stat.dt_gt1   = (dt_q > DT_W'(1));

	always_comb begin
		fresh_item                = '0;
		fresh_item.track_id       = trk_rd.ident;
		fresh_item.pos_x          = trk_rd.px;
		fresh_item.pos_y          = trk_rd.py;
		fresh_item.pos_z          = trk_rd.pz;
		fresh_item.radius         = trk_rd.rad;
		fresh_item.vel_x          = trk_rd.vx;
		fresh_item.vel_y          = trk_rd.vy;
		fresh_item.vel_z          = trk_rd.vz;
		fresh_item.is_dynamic     = trk_rd.moving;
	end

	always_comb begin
		out_d = out_q;
		unique case (cmd.emit_op)
			EM_SHIFT: begin
				out_d             = pend_q;
				out_d.dropped_any = cmd.dropped;
			end
			EM_LAST: begin
				out_d               = pend_q;
				out_d.last_of_frame = 1'b1;
				out_d.dropped_any   = cmd.dropped;
			end
			EM_EMPTY: begin
				out_d                = '0;
				out_d.last_of_frame  = 1'b1;
				out_d.no_live_tracks = 1'b1;
				out_d.dropped_any    = cmd.dropped;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q   <= GATE_RST;
			dyn_q    <= DYN_RST;
			miss_q   <= MISS_RST;
			id_q     <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_GATE: gate_q <= cfg_data;
					CFG_DYN:  dyn_q <= cfg_data;
					CFG_MISS: miss_q <= cfg_data[MISS_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.trk_we && (cmd.trk_wsel == TW_NEW)) begin
				id_q <= id_q + 1'b1;
			end
			strobe_q <= (cmd.emit_op == EM_SHIFT) || (cmd.emit_op == EM_LAST) ||
				(cmd.emit_op == EM_EMPTY);
		end
	end

	always_ff @(posedge clk) begin
		sq_s1 <= sq_full;
		if (cmd.close_lat) begin
			dt_q    <= item.frame_dt;
			gate2_q <= ACC_W'(gate_q) * ACC_W'(gate_q);
			dyn2_q  <= ACC_W'(dyn_q) * ACC_W'(dyn_q);
		end
		unique case (cmd.acc_op)
			ACC_CLR: acc_q <= '0;
			ACC_ADD: acc_q <= acc_q + sq_s1;
			default: begin
			end
		endcase
		if (cmd.bd_init) begin
			bd_q <= gate2_q;
		end else if (cmd.bd_take) begin
			bd_q <= acc_q;
		end
		if (cmd.prod_load) begin
			prod_s1 <= prod;
		end
		if (cmd.vel_init) begin
			vnx_q <= trk_rd.vx;
			vny_q <= trk_rd.vy;
			vnz_q <= trk_rd.vz;
		end else if (cmd.vel_mix) begin
			unique case (cmd.ax)
				2'd0: vnx_q <= v_sat;
				2'd1: vny_q <= v_sat;
				default: vnz_q <= v_sat;
			endcase
		end
		if ((cmd.emit_op == EM_LOAD) || (cmd.emit_op == EM_SHIFT)) begin
			pend_q <= fresh_item;
		end
		out_q <= out_d;
	end

	assign result_strobe = strobe_q;
	assign result        = out_q;

endmodule

`default_nettype wire

// ===== hdl/nearest_neighbor_track_associator_core.sv =====
// nearest_neighbor_track_associator_core: top level; uses nnta_pkg, nnta_ctrl, nnta_datapath
// load beat: busy stays low. close beat: busy while it matches each old track to the
// nearest unclaimed cluster in the gate, updates the velocity of each matched track
// (no divide when dt <= 1), compacts out stale tracks, adds new ones and emits fresh ones
// results leave one per strobe, the last one in the cycle in which busy falls; no stall
// reset clears control, counts, the id counter and strobe; stores need no clearing pass
`default_nettype none

module nearest_neighbor_track_associator_core import nnta_pkg::*; #(
	parameter int MAX_TRACKS   = DEF_MAX_TRACKS,
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire in_item_t             item,
	output logic                      result_strobe,
	output out_item_t                 result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int TAW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int CAW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

	ctrl_cmd_t      cmd;
	dp_status_t     stat;
	logic [TAW-1:0] trk_raddr;
	logic [TAW-1:0] trk_waddr;
	logic [CAW-1:0] clu_raddr;
	logic [CAW-1:0] clu_waddr;

	nnta_ctrl #(
		.MAX_TRACKS  (MAX_TRACKS),
		.MAX_CLUSTERS(MAX_CLUSTERS),
		.TAW         (TAW),
		.CAW         (CAW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.command  (item.command),
		.busy     (busy),
		.stat     (stat),
		.cmd      (cmd),
		.trk_raddr(trk_raddr),
		.trk_waddr(trk_waddr),
		.clu_raddr(clu_raddr),
		.clu_waddr(clu_waddr)
	);

	nnta_datapath #(
		.MAX_TRACKS  (MAX_TRACKS),
		.MAX_CLUSTERS(MAX_CLUSTERS),
		.TAW         (TAW),
		.CAW         (CAW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.trk_raddr    (trk_raddr),
		.trk_waddr    (trk_waddr),
		.clu_raddr    (clu_raddr),
		.clu_waddr    (clu_waddr),
		.stat         (stat),
		.result_strobe(result_strobe),
		.result       (result)
	);

endmodule

`default_nettype wire
